@@ src/mexp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mexp_pkg: shared types, constants and microcode for the modular exponent unit
// Holds the modulus, the Barrett constant, the control word layout and the
// microprogram that the sequencer steps through.
// ============================================================================
package mexp_pkg;

  // Field widths
  localparam int unsigned BaseW = 30;
  localparam int unsigned ExpW  = 63;
  localparam int unsigned ResW  = 30;

  // Prime modulus and its double
  localparam logic [29:0] MODULUS       = 30'd1000000007;
  localparam logic [30:0] TWICE_MODULUS = 31'd2000000014;

  // Barrett reciprocal floor(2^60 / MODULUS), fits in 31 bits
  localparam logic [63:0] BarrettMuWide = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_MU    = BarrettMuWide[30:0];

  // Microprogram addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE    = 3'd0;
  localparam step_t STEP_TEST    = 3'd1;
  localparam step_t STEP_MUL     = 3'd2;
  localparam step_t STEP_WAIT    = 3'd3;
  localparam step_t STEP_LOOP    = 3'd4;
  localparam step_t STEP_SPARE_A = 3'd5;
  localparam step_t STEP_SPARE_B = 3'd6;
  localparam step_t STEP_DONE    = 3'd7;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_INPUT = 3'd2,
    COND_EXP_ZERO = 3'd3,
    COND_OUT_BUSY = 3'd4
  } cond_t;

  // Write-back destination of a modular product
  typedef enum logic {
    DEST_ACC = 1'b0,
    DEST_SQ  = 1'b1
  } dest_t;

  // One control word; all actions but in_ready apply only when the jump is not taken
  typedef struct packed {
    logic  in_ready;
    logic  load_in;
    logic  issue_sq;
    logic  issue_mul;
    logic  shift_exp;
    logic  load_out;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Effective controls from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic issue_sq;
    logic issue_mul;
    logic shift_exp;
    logic load_out;
  } ctrl_t;

  // Conditions fed back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic exp_zero;
    logic out_busy;
  } status_t;

  // Microprogram ROM
  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t uc;
    uc = '0;
    unique case (addr)
      STEP_IDLE: begin
        uc.in_ready = 1'b1;
        uc.load_in  = 1'b1;
        uc.cond     = COND_NO_INPUT;
        uc.target   = STEP_IDLE;
      end
      STEP_TEST: begin
        uc.issue_sq = 1'b1;
        uc.cond     = COND_EXP_ZERO;
        uc.target   = STEP_DONE;
      end
      STEP_MUL: begin
        uc.issue_mul = 1'b1;
        uc.shift_exp = 1'b1;
      end
      STEP_WAIT: begin
        uc.cond = COND_NONE;
      end
      STEP_LOOP: begin
        uc.cond   = COND_ALWAYS;
        uc.target = STEP_TEST;
      end
      STEP_SPARE_A, STEP_SPARE_B: begin
        uc.cond   = COND_ALWAYS;
        uc.target = STEP_IDLE;
      end
      STEP_DONE: begin
        // falls through by wrapping to STEP_IDLE
        uc.load_out = 1'b1;
        uc.cond     = COND_OUT_BUSY;
        uc.target   = STEP_DONE;
      end
      default: begin
        uc.cond   = COND_ALWAYS;
        uc.target = STEP_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

@@ src/modular_exponentiation_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// modular_exponentiation_unit: base to the exponent modulo 1000000007
// Right-to-left square and multiply driven by a microcoded sequencer.
// ============================================================================
// Usage:
//   Input channel in_valid/in_ready carries in_base (30 bits) and in_exponent
//   (63 bits); output channel out_valid/out_ready carries out_power.
//   An exponent of zero yields 1; a base at or above the modulus is reduced.
//   Each pass over one exponent bit is paced by the three-stage modular
//   multiplier: the square and the conditional multiply are issued on
//   back-to-back cycles and the next pass waits for the squared value.
//   in_ready rises at the same edge as out_valid, so items are processed one
//   at a time. The output register lets a new item be accepted and computed
//   while the previous result waits; if the receiver still stalls when the
//   next result is ready, the sequencer holds in its final step until the
//   slot frees. Reset (rst_n low, synchronous) returns the sequencer to idle
//   and drops any pending result; no state carries between items.
// ============================================================================
module modular_exponentiation_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mexp_pkg::BaseW-1:0]  in_base,
  input  logic [mexp_pkg::ExpW-1:0]   in_exponent,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mexp_pkg::ResW-1:0]   out_power
);
  import mexp_pkg::*;

  ctrl_t           ctrl;
  status_t         status;
  logic            exp_zero;
  logic [ResW-1:0] acc_out;
  logic            out_valid_r;
  logic [ResW-1:0] out_power_r;

  // Gather sequencer conditions
  assign status.in_valid = in_valid;
  assign status.exp_zero = exp_zero;
  assign status.out_busy = out_valid_r & ~out_ready;

  mexp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mexp_datapath u_datapath (
    .clk         (clk),
    .ctrl        (ctrl),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .rst_n       (rst_n),
    .exp_zero    (exp_zero),
    .acc_out     (acc_out)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_power_r <= acc_out;
    end
  end

  assign in_ready  = ctrl.in_ready;
  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  // A new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a stalled beat");

  // An accepted item closes the input until its result is loaded
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice without a result");

  // Results are fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_power < MODULUS))
    else $error("result not below the modulus");

endmodule

@@ src/mexp_seq.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mexp_seq: microcode sequencer
// Steps a 3-bit program counter through the control ROM, evaluates the jump
// condition of each word and masks all actions but in_ready on a taken jump.
// ============================================================================
module mexp_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  mexp_pkg::status_t status,
  output mexp_pkg::ctrl_t   ctrl
);
  import mexp_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t uc;
  logic   taken;

  // Fetch the current control word
  assign uc = ucode_rom(step_r);

  // Evaluate the jump condition
  always_comb begin
    unique case (uc.cond)
      COND_NONE:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_INPUT: taken = ~status.in_valid;
      COND_EXP_ZERO: taken = status.exp_zero;
      COND_OUT_BUSY: taken = status.out_busy;
      default:       taken = 1'b0;
    endcase
  end

  // Jump or advance; the counter wraps from the last step to idle
  assign step_nxt = taken ? uc.target : step_t'(step_r + 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Drop actions other than in_ready of a word whose jump is taken
  always_comb begin
    ctrl.in_ready  = uc.in_ready;
    ctrl.load_in   = uc.load_in   & ~taken;
    ctrl.issue_sq  = uc.issue_sq  & ~taken;
    ctrl.issue_mul = uc.issue_mul & ~taken;
    ctrl.shift_exp = uc.shift_exp & ~taken;
    ctrl.load_out  = uc.load_out  & ~taken;
  end

endmodule

@@ src/mexp_mulmod.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mexp_mulmod: pipelined modular multiplier
// Three registered stages (product, Barrett quotient estimate, quotient times
// modulus) and a final combinational correction, which drives the write-back
// from the last stage.
// ============================================================================
module mexp_mulmod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        issue,
  input  mexp_pkg::dest_t             issue_dest,
  input  logic [mexp_pkg::ResW-1:0]   op_a,
  input  logic [mexp_pkg::ResW-1:0]   op_b,
  output logic                        wr_valid,
  output mexp_pkg::dest_t             wr_dest,
  output logic [mexp_pkg::ResW-1:0]   wr_data
);
  import mexp_pkg::*;

  // Stage registers
  logic [59:0] prod_r;
  logic [61:0] est_r;
  logic [31:0] low2_r;
  logic [31:0] low3_r;
  logic [31:0] qp_r;
  logic        v1_r, v2_r, v3_r;
  dest_t       d1_r, d2_r, d3_r;

  logic [59:0] prod_c;
  logic [61:0] est_c;
  logic [60:0] qp_c;
  logic [31:0] rem;
  logic [31:0] fixed;

  // Multipliers, one per stage
  assign prod_c = 60'(op_a) * 60'(op_b);
  assign est_c  = 62'(prod_r[59:29]) * 62'(BARRETT_MU);
  assign qp_c   = 61'(est_r[61:31]) * 61'(MODULUS);

  // Advance payload
  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    est_r  <= est_c;
    low2_r <= prod_r[31:0];
    qp_r   <= qp_c[31:0];
    low3_r <= low2_r;
    d1_r   <= issue_dest;
    d2_r   <= d1_r;
    d3_r   <= d2_r;
  end

  // Advance valid tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Remainder estimate lies below three moduli; subtract at most twice
  assign rem = low3_r - qp_r;

  always_comb begin
    priority if (rem >= {1'b0, TWICE_MODULUS}) begin
      fixed = rem - {1'b0, TWICE_MODULUS};
    end else if (rem >= {2'b00, MODULUS}) begin
      fixed = rem - {2'b00, MODULUS};
    end else begin
      fixed = rem;
    end
  end

  assign wr_valid = v3_r;
  assign wr_dest  = d3_r;
  assign wr_data  = fixed[ResW-1:0];

endmodule

@@ src/mexp_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mexp_datapath: exponent, square and accumulator registers
// Loads an item, shifts the exponent one bit per pass and issues squares and
// conditional multiplies to the modular multiplier, which writes them back.
// ============================================================================
module mexp_datapath (
  input  logic                        clk,
  input  mexp_pkg::ctrl_t             ctrl,
  input  logic [mexp_pkg::BaseW-1:0]  in_base,
  input  logic [mexp_pkg::ExpW-1:0]   in_exponent,
  input  logic                        rst_n,
  output logic                        exp_zero,
  output logic [mexp_pkg::ResW-1:0]   acc_out
);
  import mexp_pkg::*;

  logic [ResW-1:0] acc_r, acc_nxt;
  logic [ResW-1:0] sq_r, sq_nxt;
  logic [ExpW-1:0] exp_r, exp_nxt;
  logic [ResW-1:0] base_red;

  logic            issue;
  dest_t           issue_dest;
  logic [ResW-1:0] op_a;
  logic            wr_valid;
  dest_t           wr_dest;
  logic [ResW-1:0] wr_data;

  // A 30-bit base is below twice the modulus: one subtract reduces it
  assign base_red = (in_base >= MODULUS) ? (in_base - MODULUS) : in_base;

  // Issue a square, or a multiply when the current exponent bit is set
  assign issue      = ctrl.issue_sq | (ctrl.issue_mul & exp_r[0]);
  assign issue_dest = ctrl.issue_sq ? DEST_SQ : DEST_ACC;
  assign op_a       = ctrl.issue_sq ? sq_r : acc_r;

  mexp_mulmod u_mulmod (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_dest (issue_dest),
    .op_a       (op_a),
    .op_b       (sq_r),
    .wr_valid   (wr_valid),
    .wr_dest    (wr_dest),
    .wr_data    (wr_data)
  );

  // Load, shift and write back
  always_comb begin
    acc_nxt = acc_r;
    sq_nxt  = sq_r;
    exp_nxt = exp_r;
    if (ctrl.load_in) begin
      acc_nxt = ResW'(1);
      sq_nxt  = base_red;
      exp_nxt = in_exponent;
    end
    if (ctrl.shift_exp) begin
      exp_nxt = exp_r >> 1;
    end
    if (wr_valid) begin
      unique case (wr_dest)
        DEST_ACC: acc_nxt = wr_data;
        DEST_SQ:  sq_nxt  = wr_data;
        default:  acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    exp_r <= exp_nxt;
  end

  assign exp_zero = (exp_r == '0);
  assign acc_out  = acc_r;

endmodule
